### rtl/core/rate_monotonic_scheduler_assert.svh
`ifndef RATE_MONOTONIC_SCHEDULER_ASSERT_SVH
`define RATE_MONOTONIC_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define RMS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rms check failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while rst is high.
`define RMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rms check failed: next-cycle implication");

`endif

### rtl/core/rms_pkg.sv
package rms_pkg;

  localparam int NUM_TASKS   = 4;   // tasks built, 2..4
  localparam int NUM_SLOTS   = 4;   // task slots on the ports
  localparam int COUNT_WIDTH = 16;  // counter width, 8..32
  localparam int TIME_W      = 16;  // period, phase and burst width
  localparam int OUT_CNT_W   = 16;  // counter width on the result word
  localparam int TASK_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // register map: periods, then bursts
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_BASE  = 3'd4;

  // best-so-far word handed down the cell chain
  typedef struct packed {
    logic              found;
    logic [TIME_W-1:0] period;
    logic [TASK_W-1:0] idx;
  } arb_t;

  // per-cell status for the result word
  typedef struct packed {
    logic                   miss;
    logic                   finished;
    logic [COUNT_WIDTH-1:0] missed;
    logic [COUNT_WIDTH-1:0] done;
  } cell_stat_t;

endpackage

### rtl/core/rms_channels.sv
interface rms_tick_if;
  import rms_pkg::*;
  logic valid;
  logic ready;
  logic start_run;
  modport source (output valid, output start_run, input ready);
  modport sink (input valid, input start_run, output ready);
endinterface

interface rms_result_if;
  import rms_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [TASK_W-1:0]    run_task;
  logic                 idle;
  logic                 job_finished;
  logic [NUM_SLOTS-1:0] miss_mask;
  logic [OUT_CNT_W-1:0] missed_count_0;
  logic [OUT_CNT_W-1:0] missed_count_1;
  logic [OUT_CNT_W-1:0] missed_count_2;
  logic [OUT_CNT_W-1:0] missed_count_3;
  logic [OUT_CNT_W-1:0] done_count_0;
  logic [OUT_CNT_W-1:0] done_count_1;
  logic [OUT_CNT_W-1:0] done_count_2;
  logic [OUT_CNT_W-1:0] done_count_3;
  modport source (output valid, output run_task, output idle, output job_finished,
                  output miss_mask, output missed_count_0, output missed_count_1,
                  output missed_count_2, output missed_count_3, output done_count_0,
                  output done_count_1, output done_count_2, output done_count_3,
                  input ready);
  modport sink (input valid, input run_task, input idle, input job_finished,
                input miss_mask, input missed_count_0, input missed_count_1,
                input missed_count_2, input missed_count_3, input done_count_0,
                input done_count_1, input done_count_2, input done_count_3,
                output ready);
endinterface

interface rms_cfg_if;
  import rms_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/rate_monotonic_scheduler.sv
// Rate-monotonic scheduler for up to four periodic tasks. Each word taken on
// the tick channel is one timer tick and yields exactly one result word:
// which task ran (run_task, or idle), whether its job finished, which tasks
// were released with work still left (miss_mask), and the saturating miss
// and completion counters after the tick. A task is a row cell holding its
// phase, remaining burst and counters; the cells hand a best-so-far word
// (found, period, index) down the row, so the shortest period wins and equal
// periods go to the lower index, and the winner at the end of the row is fed
// back as the grant. start_run=1 zeroes phases, bursts and counters before
// its tick; periods and bursts are kept. Period 0 disables a task. Every
// enabled task is released on the first tick after reset or start_run.
// Throughput is one tick per clock: the whole decision is one pass through
// the cell row, and a single output register holds the result word, so a
// tick is taken whenever that register is empty or being emptied. The user
// must write registers through cfg (index 0..3 periods, 4..7 bursts) only
// while no tick is in flight; the block itself does not enforce this.
module rate_monotonic_scheduler
  import rms_pkg::*;
(
  input logic         clk,
  input logic         rst,
  rms_tick_if.sink    tick,
  rms_result_if.source result,
  rms_cfg_if.sink     cfg
);

  logic [TIME_W-1:0] period_q [NUM_SLOTS];
  logic [TIME_W-1:0] burst_q  [NUM_SLOTS];

  arb_t       arb   [NUM_SLOTS+1];
  cell_stat_t stat  [NUM_SLOTS];
  arb_t       grant;
  logic       step;
  logic       res_valid;

  // config: always ready, low half of the map is periods
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        period_q[i] <= '0;
        burst_q[i]  <= '0;
      end
    end else if (cfg.valid) begin
      if (cfg.index < REG_BURST_BASE) begin
        period_q[cfg.index[TASK_W-1:0] - REG_PERIOD_BASE[TASK_W-1:0]] <= cfg.data;
      end else begin
        burst_q[cfg.index[TASK_W-1:0] - REG_BURST_BASE[TASK_W-1:0]] <= cfg.data;
      end
    end
  end

  // take a tick when the result slot is free or draining
  assign tick.ready = !res_valid || result.ready;
  assign step       = tick.valid && tick.ready;

  // cell row: head of the chain starts with nothing found
  assign arb[0] = '{found: 1'b0, period: '0, idx: '0};
  assign grant  = arb[NUM_SLOTS];

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_slot
    if (g < NUM_TASKS) begin : g_task
      rms_cell u_cell (
        .clk     (clk),
        .rst     (rst),
        .step    (step),
        .clear   (tick.start_run),
        .my_idx  (TASK_W'(g)),
        .period  (period_q[g]),
        .burst   (burst_q[g]),
        .arb_in  (arb[g]),
        .grant   (grant),
        .arb_out (arb[g+1]),
        .stat    (stat[g])
      );
    end else begin : g_absent
      // unbuilt slot: never ready, counters read zero
      assign arb[g+1] = arb[g];
      assign stat[g]  = '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result.run_task       <= grant.found ? grant.idx : '0;
      result.idle           <= !grant.found;
      result.job_finished   <= stat[0].finished | stat[1].finished |
                               stat[2].finished | stat[3].finished;
      result.miss_mask      <= {stat[3].miss, stat[2].miss, stat[1].miss, stat[0].miss};
      result.missed_count_0 <= OUT_CNT_W'(stat[0].missed);
      result.missed_count_1 <= OUT_CNT_W'(stat[1].missed);
      result.missed_count_2 <= OUT_CNT_W'(stat[2].missed);
      result.missed_count_3 <= OUT_CNT_W'(stat[3].missed);
      result.done_count_0   <= OUT_CNT_W'(stat[0].done);
      result.done_count_1   <= OUT_CNT_W'(stat[1].done);
      result.done_count_2   <= OUT_CNT_W'(stat[2].done);
      result.done_count_3   <= OUT_CNT_W'(stat[3].done);
    end
  end

  assign result.valid = res_valid;

`include "rate_monotonic_scheduler_assert.svh"

  // an idle tick never finishes a job
  `RMS_ASSERT_NOW(a_idle_no_finish, result.valid && result.idle, !result.job_finished)
  // a held result blocks the tick side
  `RMS_ASSERT_NOW(a_stall_blocks, result.valid && !result.ready, !tick.ready)
  // a granted task has a nonzero period
  `RMS_ASSERT_NEXT(a_grant_enabled, step && grant.found && !cfg.valid,
                   period_q[result.run_task] != '0)

endmodule

### rtl/core/rms_cell.sv
module rms_cell
  import rms_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              clear,
  input  logic [TASK_W-1:0] my_idx,
  input  logic [TIME_W-1:0] period,
  input  logic [TIME_W-1:0] burst,
  input  arb_t              arb_in,
  input  arb_t              grant,
  output arb_t              arb_out,
  output cell_stat_t        stat
);

  logic [TIME_W-1:0]      phase, remaining;
  logic [COUNT_WIDTH-1:0] missed, done;

  logic [TIME_W-1:0]      ph, rem, rem_rel;
  logic [COUNT_WIDTH-1:0] mc, dc;
  logic [TIME_W:0]        ph_inc;
  logic                   enabled, release_now, ready, granted;
  logic [TIME_W-1:0]      phase_next, remaining_next;
  logic [COUNT_WIDTH-1:0] missed_next, done_next;

  always_comb begin
    // start_run clears the run state ahead of this tick
    ph  = clear ? '0 : phase;
    rem = clear ? '0 : remaining;
    mc  = clear ? '0 : missed;
    dc  = clear ? '0 : done;

    enabled     = (period != '0);
    release_now = enabled && (ph == '0);
    stat.miss   = release_now && (rem != '0);

    if (!enabled) begin
      rem_rel = '0;
    end else if (release_now) begin
      rem_rel = burst;
    end else begin
      rem_rel = rem;
    end
    ready = (rem_rel != '0);

    // strict less keeps the lower index on equal periods
    if (ready && (!arb_in.found || period < arb_in.period)) begin
      arb_out = '{found: 1'b1, period: period, idx: my_idx};
    end else begin
      arb_out = arb_in;
    end

    granted        = grant.found && (grant.idx == my_idx);
    stat.finished  = granted && (rem_rel == TIME_W'(1));
    remaining_next = granted ? rem_rel - TIME_W'(1) : rem_rel;

    ph_inc = {1'b0, ph} + (TIME_W+1)'(1);
    if (!enabled || ph_inc >= {1'b0, period}) begin
      phase_next = '0;
    end else begin
      phase_next = ph_inc[TIME_W-1:0];
    end

    missed_next = (stat.miss && mc != '1) ? mc + COUNT_WIDTH'(1) : mc;
    done_next   = (stat.finished && dc != '1) ? dc + COUNT_WIDTH'(1) : dc;
    stat.missed = missed_next;
    stat.done   = done_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      remaining <= '0;
      missed    <= '0;
      done      <= '0;
    end else if (step) begin
      phase     <= phase_next;
      remaining <= remaining_next;
      missed    <= missed_next;
      done      <= done_next;
    end
  end

endmodule
